@@ rtl/first_fit_page_bitmap_allocator_macros.svh @@
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define FFPBA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FFPBA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ffpba_pkg.sv @@
// shared types and constants of the first-fit page allocator
package ffpba_pkg;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned SIZE_W     = 32;
    localparam int unsigned REQ_PAGE_W = SIZE_W - PAGE_SHIFT;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } t_state;

endpackage

@@ rtl/first_fit_page_bitmap_allocator.sv @@
// first-fit page allocator: top level with scan sequencer over the page-use ram
// after reset a clearing pass writes every page free; no item is taken meanwhile
// one item: accept, a scan of one page per cycle, marking of the granted pages as used,
// then a load of the result register
// an oversized request skips the scan; done holds while the previous result is unread
// reset is synchronous active low; region_base resets to 0 and every page to free
module first_fit_page_bitmap_allocator
    import ffpba_pkg::*;
#(
    parameter int unsigned MAP_PAGES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write: region_base
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ADDR_W-1:0] i_cfg_data,   // [47:0] region_base
    // request items
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [SIZE_W-1:0] i_s_tdata,    // [31:0] request_size
    // result items
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [ADDR_W-1:0] o_m_tdata,    // [47:0] region_address
    output logic [0:0]        o_m_tuser     // [0] granted
);

`include "first_fit_page_bitmap_allocator_macros.svh"

    localparam int unsigned AW = $clog2(MAP_PAGES);       // page index width
    localparam int unsigned PW = $clog2(MAP_PAGES + 1);   // page count width
    localparam logic [AW-1:0] LAST_IDX = AW'(MAP_PAGES - 1);

    // sequencer
    t_state r_state, n_state;

    // config
    logic [ADDR_W-1:0] r_base;

    // request and scan state
    logic [PW-1:0] r_pages;
    logic [PW-1:0] r_run;
    logic [AW-1:0] r_scan_idx;    // address issued to the ram
    logic          r_issue_end;   // last page address already issued
    logic [AW-1:0] r_eval_idx;    // page whose use bit is on the ram output
    logic          r_eval_vld;
    logic [AW-1:0] r_start;
    logic          r_grant;

    // clearing pass and marking
    logic [AW-1:0] r_clr_idx;
    logic [AW-1:0] r_mark_idx;
    logic [PW-1:0] r_left;

    // result register
    logic              r_out_vld;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_grant;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_wa;
    logic          ram_wd;
    logic          ram_q;     // 1 = page used

    // sequencer outputs
    logic s_ready;
    logic out_load;

    // scan evaluation
    logic          accept;
    logic          req_big;
    logic          ev_free;
    logic [PW-1:0] run_inc;
    logic          scan_hit;
    logic          scan_miss;
    logic [PW-1:0] hit_diff;
    logic [AW-1:0] hit_start;

    ffpba_ram #(
        .P_WIDTH (1),
        .P_DEPTH (MAP_PAGES)
    ) u_use_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_addr (r_scan_idx),
        .o_rd_data (ram_q)
    );

    assign accept  = i_s_tvalid && s_ready;
    // more pages than the map holds can never fit
    assign req_big = i_s_tdata[SIZE_W-1:PAGE_SHIFT] > REQ_PAGE_W'(MAP_PAGES);

    // one page per cycle: extend the free run or restart it
    assign ev_free   = !ram_q;
    assign run_inc   = r_run + PW'(1);
    assign scan_hit  = r_eval_vld && ev_free && ((r_pages == '0) || (run_inc == r_pages));
    assign scan_miss = r_eval_vld && !scan_hit && (r_eval_idx == LAST_IDX);
    // run ends here, so it began pages - 1 entries back
    assign hit_diff  = PW'(r_eval_idx) + PW'(1) - r_pages;
    assign hit_start = (r_pages == '0) ? r_eval_idx : hit_diff[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = req_big ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    n_state = (r_pages == '0) ? ST_DONE : ST_MARK;
                end else if (scan_miss) begin
                    n_state = ST_DONE;
                end
            end
            ST_MARK: begin
                if (r_left == PW'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        ram_we   = 1'b0;
        ram_wa   = r_clr_idx;
        ram_wd   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_MARK: begin
                ram_we = 1'b1;
                ram_wa = r_mark_idx;
                ram_wd = 1'b1;
            end
            ST_DONE: begin
                out_load = !r_out_vld || i_m_tready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_base      <= '0;
            r_clr_idx   <= '0;
            r_eval_vld  <= 1'b0;
            r_issue_end <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end

            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end

            // page address issue, one a cycle until the last page
            if (accept) begin
                r_scan_idx  <= '0;
                r_issue_end <= 1'b0;
            end else if (r_state == ST_SCAN && !r_issue_end) begin
                r_scan_idx <= r_scan_idx + AW'(1);
                if (r_scan_idx == LAST_IDX) begin
                    r_issue_end <= 1'b1;
                end
            end
            r_eval_vld <= (r_state == ST_SCAN) && !r_issue_end && !scan_hit;
            r_eval_idx <= r_scan_idx;

            if (accept) begin
                r_run   <= '0;
                r_pages <= i_s_tdata[PAGE_SHIFT +: PW];
                r_grant <= 1'b0;
            end else if (r_eval_vld) begin
                r_run <= ev_free ? run_inc : '0;
                if (scan_hit) begin
                    r_grant    <= 1'b1;
                    r_start    <= hit_start;
                    r_mark_idx <= hit_start;
                    r_left     <= r_pages;
                end
            end

            if (r_state == ST_MARK) begin
                r_mark_idx <= r_mark_idx + AW'(1);
                r_left     <= r_left - PW'(1);
            end

            // result register parts the scan from the output side
            if (out_load) begin
                r_out_vld   <= 1'b1;
                r_out_grant <= r_grant;
                r_out_addr  <= r_grant ? r_base + (ADDR_W'(r_start) << PAGE_SHIFT) : '0;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_s_tready   = s_ready;
    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_addr;
    assign o_m_tuser[0] = r_out_grant;

    // a scan result is looked at only while scanning
    `FFPBA_ASSERT_NOW(a_eval_in_scan, i_clk, i_rst_n, r_eval_vld, r_state == ST_SCAN,
        "page evaluated outside scan")
    // a failed request always reports address zero
    `FFPBA_ASSERT_NOW(a_fail_addr_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0],
        o_m_tdata == '0, "failed item with nonzero address")
    // page map is only written by the clearing pass or by marking
    `FFPBA_ASSERT_NOW(a_write_phase, i_clk, i_rst_n, ram_we,
        r_state == ST_CLEAR || r_state == ST_MARK, "page map written outside clear or mark")
    // a new result is loaded only at the end of an item
    `FFPBA_ASSERT_NEXT(a_load_after_done, i_clk, i_rst_n, r_state != ST_DONE && !o_m_tvalid,
        !o_m_tvalid, "result appeared without finishing an item")

endmodule

@@ rtl/ffpba_ram.sv @@
// generic single write port ram with registered read
module ffpba_ram #(
    parameter int unsigned P_WIDTH = 1,
    parameter int unsigned P_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(P_DEPTH)-1:0] i_rd_addr,
    output logic [P_WIDTH-1:0]         o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
